>>> rtl/bop_pkg.sv
// Shared types, constants and helpers for the binomial option pricer.
// Used by bop_mul_unit and binomial_european_option_pricer_core; no dependencies.
`default_nettype none

package bop_pkg;

  // Default tree depth limit
  localparam int unsigned MAX_STEPS_DEF = 128;

  // Fixed-point constants
  localparam logic [31:0] Q30_ONE = 32'h4000_0000;
  localparam logic [31:0] SAT32   = 32'hFFFF_FFFF;

  // Configuration register indexes
  localparam logic [2:0] CFG_UP_FACTOR    = 3'd0;
  localparam logic [2:0] CFG_DOWN_FACTOR  = 3'd1;
  localparam logic [2:0] CFG_PROB_UP      = 3'd2;
  localparam logic [2:0] CFG_STEP_DISC    = 3'd3;
  localparam logic [2:0] CFG_TREE_STEPS   = 3'd4;

  // Option kinds
  localparam logic KIND_CALL = 1'b0;
  localparam logic KIND_PUT  = 1'b1;

  // Shared multiplier operation
  typedef enum logic [1:0] {
    MUL_HOLD = 2'd0,
    MUL_LOAD = 2'd1,
    MUL_ADD  = 2'd2
  } bop_mode_e;

  typedef struct packed {
    bop_mode_e   mode;
    logic [31:0] a;
    logic [31:0] b;
  } bop_mul_op_t;

  // (x >> 30) saturated to 32 bits
  function automatic logic [31:0] sat_q30(input logic [63:0] x);
    logic [31:0] r;
    if (x[63:62] != 2'b00) begin
      r = SAT32;
    end else begin
      r = x[61:30];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/bop_mul_unit.sv
// Shared 32x32 multiply-accumulate unit with Q2.30 rescale and saturation.
// Depends on bop_pkg for the operation struct and the saturation helper.
`default_nettype none

module bop_mul_unit (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire bop_pkg::bop_mul_op_t op_i,
  output logic [31:0]               res_o,
  output logic [31:0]               acc_sat_o
);
  import bop_pkg::*;

  logic [63:0] prod;
  logic [63:0] acc_d;
  logic [63:0] acc_q;

  // One product per cycle, optionally accumulated
  always_comb begin
    prod = 64'(op_i.a) * 64'(op_i.b);
    unique case (op_i.mode)
      MUL_HOLD: acc_d = acc_q;
      MUL_LOAD: acc_d = prod;
      MUL_ADD:  acc_d = acc_q + prod;
      default:  acc_d = acc_q;
    endcase
  end

  // Accumulator
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign res_o     = sat_q30(acc_d);
  assign acc_sat_o = sat_q30(acc_q);

endmodule

`default_nettype wire

>>> rtl/binomial_european_option_pricer_core.sv
// Top level of the CRR binomial European option pricer.
// Depends on bop_pkg and bop_mul_unit.
//
// Usage: configuration is written through cfg_we_i/cfg_index_i/cfg_data_i while
// the block is idle (index 0 up factor, 1 down factor, 2 up probability,
// 3 step discount, 4 tree steps). An input beat (spot, strike, option kind)
// is taken on in_valid_i & in_ready_o; one result beat (price) leaves on
// out_valid_o & out_ready_i.
// Sequencing: one item at a time through a single shared multiplier. With n tree
// steps each of the n+1 leaves takes n products (S_LEAF_MUL) and a write
// (S_LEAF_WR); each of the n(n+1)/2 rollback nodes passes S_NODE_M1, S_NODE_M2
// and S_NODE_M3, and each rollback row first reloads its row head (S_ROW_A,
// S_ROW_B). The node store has one write and one read port.
// Reset restores the default configuration and empties the pipeline; the node
// store is not cleared (every entry is written before it is read).
// A stalled receiver holds the price register; the next item is still taken
// and finishes its tree, then waits until the held beat has gone.
`default_nettype none

module binomial_european_option_pricer_core #(
  parameter int unsigned MAX_STEPS = bop_pkg::MAX_STEPS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  // input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [31:0] spot_i,
  input  wire logic [31:0] strike_i,
  input  wire logic        option_kind_i,
  // output channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      price_o
);
  import bop_pkg::*;

  localparam int unsigned DEPTH = MAX_STEPS + 1;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = (AW > 8) ? AW : 8;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LEAF_MUL,
    S_LEAF_WR,
    S_ROW_A,
    S_ROW_B,
    S_NODE_M1,
    S_NODE_M2,
    S_NODE_M3,
    S_FIN
  } state_e;

  // Configuration registers
  logic [31:0] up_q, down_q;
  logic [30:0] prob_q, disc_q;
  logic [7:0]  steps_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      up_q    <= Q30_ONE;
      down_q  <= Q30_ONE;
      prob_q  <= 31'(Q30_ONE >> 1);
      disc_q  <= 31'(Q30_ONE);
      steps_q <= 8'd100;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_UP_FACTOR:   up_q    <= cfg_data_i;
        CFG_DOWN_FACTOR: down_q  <= cfg_data_i;
        CFG_PROB_UP:     prob_q  <= cfg_data_i[30:0];
        CFG_STEP_DISC:   disc_q  <= cfg_data_i[30:0];
        CFG_TREE_STEPS:  steps_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Per-item setup values
  logic [CW-1:0] steps_ext;
  logic [AW-1:0] n_in;
  logic [30:0]   p_in;

  always_comb begin
    steps_ext = CW'(steps_q);
    n_in = (steps_ext > CW'(MAX_STEPS)) ? AW'(MAX_STEPS) : AW'(steps_ext);
    p_in = (prob_q > 31'(Q30_ONE)) ? 31'(Q30_ONE) : prob_q;
  end

  // Node store
  logic [31:0]   mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  // Sequencer registers
  state_e        state_q;
  logic [AW-1:0] n_q, i_q, j_q, k_q;
  logic [31:0]   spot_q, strike_q, s_q, vcur_q, last_q, price_q;
  logic [30:0]   p_q, q_q;
  logic          kind_q, out_valid_q;

  // Shared multiplier
  bop_mul_op_t   mul_op;
  logic [31:0]   mul_res, mul_acc_sat;

  bop_mul_unit u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (mul_op),
    .res_o     (mul_res),
    .acc_sat_o (mul_acc_sat)
  );

  logic [AW-1:0] up_cnt;
  logic [31:0]   payoff;
  logic          in_fire;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign up_cnt     = n_q - i_q;

  // Payoff of the current leaf price
  always_comb begin
    if (kind_q == KIND_PUT) begin
      payoff = (strike_q > s_q) ? (strike_q - s_q) : 32'd0;
    end else begin
      payoff = (s_q > strike_q) ? (s_q - strike_q) : 32'd0;
    end
  end

  // Operand select, store access
  always_comb begin
    mul_op.mode = MUL_HOLD;
    mul_op.a    = s_q;
    mul_op.b    = up_q;
    mem_we      = 1'b0;
    mem_waddr   = i_q;
    mem_wdata   = mul_res;
    mem_re      = 1'b0;
    mem_raddr   = i_q + AW'(2);
    unique case (state_q)
      S_LEAF_MUL: begin
        mul_op.mode = MUL_LOAD;
        mul_op.b    = (k_q < up_cnt) ? up_q : down_q;
      end
      S_LEAF_WR: begin
        mem_we    = 1'b1;
        mem_wdata = payoff;
      end
      S_ROW_A: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      S_ROW_B: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(1);
      end
      S_NODE_M1: begin
        mul_op.mode = MUL_LOAD;
        mul_op.a    = vcur_q;
        mul_op.b    = {1'b0, p_q};
      end
      S_NODE_M2: begin
        mul_op.mode = MUL_ADD;
        mul_op.a    = rdata_q;
        mul_op.b    = {1'b0, q_q};
      end
      S_NODE_M3: begin
        mul_op.mode = MUL_LOAD;
        mul_op.a    = mul_acc_sat;
        mul_op.b    = {1'b0, disc_q};
        mem_we      = 1'b1;
        mem_re      = ((i_q + AW'(1)) < j_q);
      end
      default: ;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
    end else begin
      // S_FIN reloads the output itself
      if (out_valid_q && out_ready_i && (state_q != S_FIN)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            spot_q   <= spot_i;
            strike_q <= strike_i;
            kind_q   <= option_kind_i;
            s_q      <= spot_i;
            n_q      <= n_in;
            p_q      <= p_in;
            q_q      <= 31'(Q30_ONE) - p_in;
            i_q      <= '0;
            k_q      <= '0;
            state_q  <= (n_in == '0) ? S_LEAF_WR : S_LEAF_MUL;
          end
        end
        S_LEAF_MUL: begin
          s_q <= mul_res;
          if (k_q == n_q - AW'(1)) begin
            k_q     <= '0;
            state_q <= S_LEAF_WR;
          end else begin
            k_q <= k_q + AW'(1);
          end
        end
        S_LEAF_WR: begin
          last_q <= payoff;
          s_q    <= spot_q;
          if (i_q == n_q) begin
            i_q     <= '0;
            j_q     <= n_q;
            state_q <= (n_q == '0) ? S_FIN : S_ROW_A;
          end else begin
            i_q     <= i_q + AW'(1);
            state_q <= S_LEAF_MUL;
          end
        end
        S_ROW_A: state_q <= S_ROW_B;
        S_ROW_B: begin
          vcur_q  <= rdata_q;
          state_q <= S_NODE_M1;
        end
        S_NODE_M1: state_q <= S_NODE_M2;
        S_NODE_M2: state_q <= S_NODE_M3;
        S_NODE_M3: begin
          last_q <= mul_res;
          vcur_q <= rdata_q;
          if ((i_q + AW'(1)) < j_q) begin
            i_q     <= i_q + AW'(1);
            state_q <= S_NODE_M1;
          end else if (j_q == AW'(1)) begin
            state_q <= S_FIN;
          end else begin
            i_q     <= '0;
            j_q     <= j_q - AW'(1);
            state_q <= S_ROW_A;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            price_q     <= last_q;
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign price_o     = price_q;

endmodule

`default_nettype wire
